/* hdl/lfd_pkg.sv */
package lfd_pkg;

   localparam int LIGHT_W  = 10;
   localparam int KNOB_W   = 10;
   localparam int DUTY_W   = 8;
   localparam int GAIN_W   = 16;
   localparam int SPEED_W  = 8;
   localparam int OFFSET_W = 10;
   localparam int THRESH_W = 11;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE_SELECT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEERING_GAIN = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEFT_BASE     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEFT_SPAN     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RIGHT_BASE    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_RIGHT_SPAN    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_CALIB_OFFSET  = 3'd6;

   localparam logic MODE_PROPORTIONAL = 1'b0;
   localparam logic MODE_BANG_BANG    = 1'b1;

   localparam logic [GAIN_W-1:0]   GAIN_RESET       = 16'd45;
   localparam logic [SPEED_W-1:0]  LEFT_BASE_RESET  = 8'd35;
   localparam logic [SPEED_W-1:0]  LEFT_SPAN_RESET  = 8'd40;
   localparam logic [SPEED_W-1:0]  RIGHT_BASE_RESET = 8'd50;
   localparam logic [SPEED_W-1:0]  RIGHT_SPAN_RESET = 8'd60;
   localparam logic [OFFSET_W-1:0] OFFSET_RESET     = 10'd150;
   localparam logic [THRESH_W-1:0] THRESH_RESET     = 11'd300;

   // steering product over 10000 as multiply by reciprocal
   localparam int STEER_PROD_W  = LIGHT_W + GAIN_W;
   localparam int STEER_SHIFT   = 40;
   localparam int STEER_RECIP_W = 27;
   localparam longint STEER_DIVISOR = 10000;
   localparam logic [STEER_RECIP_W-1:0] STEER_RECIP =
      STEER_RECIP_W'(((64'd1 << STEER_SHIFT) + STEER_DIVISOR - 1) / STEER_DIVISOR);
   localparam int STEER_FULL_W  = STEER_PROD_W + STEER_RECIP_W;
   localparam int STEER_Q_W     = 13;

   // four fifths as multiply by reciprocal
   localparam int FIFTH_SHIFT   = 13;
   localparam int FIFTH_W       = 22;
   localparam logic [FIFTH_W-1:0] FIFTH_RECIP = FIFTH_W'(((1 << FIFTH_SHIFT) + 4) / 5);

   localparam int KNOB_PROD_W = KNOB_W + SPEED_W;
   localparam int BASE_W      = SPEED_W + 1;
   localparam int DRIVE_W     = 16;

   typedef struct packed {
      logic [LIGHT_W-1:0] left_light;
      logic [LIGHT_W-1:0] right_light;
      logic [KNOB_W-1:0]  speed_knob;
      logic               calibrate;
   } req_word_type;

   typedef struct packed {
      logic [DUTY_W-1:0] left_duty;
      logic              left_reverse;
      logic [DUTY_W-1:0] right_duty;
      logic              right_reverse;
   } rsp_word_type;

endpackage

/* hdl/line_follower_drive.sv */
// Two-sensor line follower motor drive. Each request word carries two light samples, the
// speed knob and a calibrate flag; each yields one response word with sign/magnitude
// commands for both motors. One word is accepted every cycle unless req_stall holds it;
// its response passes the three register stages behind the input register, which split
// the knob and steering multiplications from their constant reciprocal corrections.
// Calibration updates the threshold at acceptance, so the next word already sees it.
// The user must write registers via csr_ only while idle; the block does not enforce it.
module line_follower_drive (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  lfd_pkg::req_word_type             req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output lfd_pkg::rsp_word_type             rsp_word,
   input  logic                              csr_wr_en,
   input  logic [lfd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lfd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   function automatic logic [lfd_pkg::DUTY_W:0] drive(input logic signed [lfd_pkg::DRIVE_W-1:0] s);
      logic signed [lfd_pkg::DRIVE_W-1:0] v;
      v = -s;
      if (v > 16'sd255) begin
         v = 16'sd255;
      end else if (v < -16'sd255) begin
         v = -16'sd255;
      end
      if (v >= 16'sd0) begin
         drive = {1'b0, v[lfd_pkg::DUTY_W-1:0]};
      end else begin
         v = -v;
         drive = {1'b1, v[lfd_pkg::DUTY_W-1:0]};
      end
   endfunction

   logic                              mode_ff;
   logic [lfd_pkg::GAIN_W-1:0]        gain_ff;
   logic [lfd_pkg::SPEED_W-1:0]       left_base_ff;
   logic [lfd_pkg::SPEED_W-1:0]       left_span_ff;
   logic [lfd_pkg::SPEED_W-1:0]       right_base_ff;
   logic [lfd_pkg::SPEED_W-1:0]       right_span_ff;
   logic [lfd_pkg::OFFSET_W-1:0]      offset_ff;
   logic [lfd_pkg::THRESH_W-1:0]      thresh_ff;
   logic [lfd_pkg::THRESH_W-1:0]      thresh_in;

   logic adv_a, adv_b, adv_c, adv_d, accept;

   // stage A: input register
   logic                              a_v_ff;
   logic [lfd_pkg::LIGHT_W-1:0]       a_left_ff, a_right_ff;
   logic [lfd_pkg::KNOB_W-1:0]        a_knob_ff;
   logic [lfd_pkg::THRESH_W-1:0]      a_thresh_ff;

   // stage B: products and classification
   logic                              b_v_ff;
   logic [lfd_pkg::KNOB_PROD_W-1:0]   b_lprod_ff, b_rprod_ff, b_lprod_in, b_rprod_in;
   logic [lfd_pkg::STEER_PROD_W-1:0]  b_eprod_ff, b_eprod_in;
   logic [lfd_pkg::LIGHT_W-1:0]       b_abserr_in;
   logic                              b_neg_ff, b_neg_in;
   logic [3:0]                        b_flags_ff, b_flags_in;

   // stage C: base speeds and steering quotient
   logic                              c_v_ff;
   logic [lfd_pkg::BASE_W-1:0]        c_lb_ff, c_rb_ff, c_lb_in, c_rb_in;
   logic [lfd_pkg::STEER_Q_W-1:0]     c_q_ff, c_q_in;
   logic                              c_neg_ff;
   logic [3:0]                        c_flags_ff;
   logic [lfd_pkg::KNOB_PROD_W:0]     c_lsum, c_rsum;
   logic [lfd_pkg::STEER_FULL_W-1:0]  c_full;

   // stage D: response register
   logic                              rsp_valid_ff;
   lfd_pkg::rsp_word_type             rsp_word_ff, rsp_word_in;
   logic signed [lfd_pkg::DRIVE_W-1:0] d_steer, d_sl, d_sr, d_revl, d_revr;
   logic [lfd_pkg::FIFTH_W-1:0]       d_lfifth, d_rfifth;
   logic [lfd_pkg::DUTY_W:0]          d_ldrv, d_rdrv;
   logic                              d_d1, d_d2, d_le1, d_le2;

   assign adv_d     = !rsp_valid_ff || !rsp_stall;
   assign adv_c     = !c_v_ff || adv_d;
   assign adv_b     = !b_v_ff || adv_c;
   assign adv_a     = !a_v_ff || adv_b;
   assign req_stall = !adv_a;
   assign accept    = req_valid && adv_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= lfd_pkg::MODE_PROPORTIONAL;
         gain_ff       <= lfd_pkg::GAIN_RESET;
         left_base_ff  <= lfd_pkg::LEFT_BASE_RESET;
         left_span_ff  <= lfd_pkg::LEFT_SPAN_RESET;
         right_base_ff <= lfd_pkg::RIGHT_BASE_RESET;
         right_span_ff <= lfd_pkg::RIGHT_SPAN_RESET;
         offset_ff     <= lfd_pkg::OFFSET_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            lfd_pkg::CSR_MODE_SELECT:   mode_ff       <= csr_wdata[0];
            lfd_pkg::CSR_STEERING_GAIN: gain_ff       <= csr_wdata;
            lfd_pkg::CSR_LEFT_BASE:     left_base_ff  <= csr_wdata[lfd_pkg::SPEED_W-1:0];
            lfd_pkg::CSR_LEFT_SPAN:     left_span_ff  <= csr_wdata[lfd_pkg::SPEED_W-1:0];
            lfd_pkg::CSR_RIGHT_BASE:    right_base_ff <= csr_wdata[lfd_pkg::SPEED_W-1:0];
            lfd_pkg::CSR_RIGHT_SPAN:    right_span_ff <= csr_wdata[lfd_pkg::SPEED_W-1:0];
            lfd_pkg::CSR_CALIB_OFFSET:  offset_ff     <= csr_wdata[lfd_pkg::OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [lfd_pkg::LIGHT_W:0] sum;
      sum = {1'b0, req_word.left_light} + {1'b0, req_word.right_light};
      thresh_in = thresh_ff;
      if (req_word.calibrate) begin
         thresh_in = {1'b0, sum[lfd_pkg::LIGHT_W:1]} + {1'b0, offset_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= lfd_pkg::THRESH_RESET;
      end else if (accept) begin
         thresh_ff <= thresh_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (adv_a) begin
         a_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_left_ff   <= req_word.left_light;
         a_right_ff  <= req_word.right_light;
         a_knob_ff   <= req_word.speed_knob;
         a_thresh_ff <= thresh_in;
      end
   end

   always_comb begin
      b_lprod_in  = lfd_pkg::KNOB_PROD_W'(a_knob_ff) * lfd_pkg::KNOB_PROD_W'(left_span_ff);
      b_rprod_in  = lfd_pkg::KNOB_PROD_W'(a_knob_ff) * lfd_pkg::KNOB_PROD_W'(right_span_ff);
      b_neg_in    = a_left_ff < a_right_ff;
      b_abserr_in = b_neg_in ? a_right_ff - a_left_ff : a_left_ff - a_right_ff;
      b_eprod_in  = lfd_pkg::STEER_PROD_W'(b_abserr_in) * lfd_pkg::STEER_PROD_W'(gain_ff);
      b_flags_in  = {{1'b0, a_left_ff} >= a_thresh_ff,
                     {1'b0, a_right_ff} >= a_thresh_ff,
                     {1'b0, a_left_ff} <= a_thresh_ff,
                     {1'b0, a_right_ff} <= a_thresh_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (adv_b) begin
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_b) begin
         b_lprod_ff <= b_lprod_in;
         b_rprod_ff <= b_rprod_in;
         b_eprod_ff <= b_eprod_in;
         b_neg_ff   <= b_neg_in;
         b_flags_ff <= b_flags_in;
      end
   end

   always_comb begin
      c_lsum  = (lfd_pkg::KNOB_PROD_W+1)'(b_lprod_ff) + (lfd_pkg::KNOB_PROD_W+1)'(b_lprod_ff >> 10)
                + (lfd_pkg::KNOB_PROD_W+1)'(1);
      c_rsum  = (lfd_pkg::KNOB_PROD_W+1)'(b_rprod_ff) + (lfd_pkg::KNOB_PROD_W+1)'(b_rprod_ff >> 10)
                + (lfd_pkg::KNOB_PROD_W+1)'(1);
      c_lb_in = lfd_pkg::BASE_W'(left_base_ff) + c_lsum[lfd_pkg::KNOB_PROD_W:10];
      c_rb_in = lfd_pkg::BASE_W'(right_base_ff) + c_rsum[lfd_pkg::KNOB_PROD_W:10];
      c_full  = lfd_pkg::STEER_FULL_W'(b_eprod_ff) * lfd_pkg::STEER_FULL_W'(lfd_pkg::STEER_RECIP);
      c_q_in  = c_full[lfd_pkg::STEER_SHIFT +: lfd_pkg::STEER_Q_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (adv_c) begin
         c_v_ff <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_c) begin
         c_lb_ff    <= c_lb_in;
         c_rb_ff    <= c_rb_in;
         c_q_ff     <= c_q_in;
         c_neg_ff   <= b_neg_ff;
         c_flags_ff <= b_flags_ff;
      end
   end

   always_comb begin
      {d_d1, d_d2, d_le1, d_le2} = c_flags_ff;
      d_steer  = lfd_pkg::DRIVE_W'(c_q_ff);
      if (c_neg_ff) begin
         d_steer = -d_steer;
      end
      d_lfifth = lfd_pkg::FIFTH_W'({c_lb_ff, 2'b00}) * lfd_pkg::FIFTH_RECIP;
      d_rfifth = lfd_pkg::FIFTH_W'({c_rb_ff, 2'b00}) * lfd_pkg::FIFTH_RECIP;
      d_revl   = -lfd_pkg::DRIVE_W'(d_lfifth[lfd_pkg::FIFTH_W-1:lfd_pkg::FIFTH_SHIFT]);
      d_revr   = -lfd_pkg::DRIVE_W'(d_rfifth[lfd_pkg::FIFTH_W-1:lfd_pkg::FIFTH_SHIFT]);
      d_sl     = d_revl;
      d_sr     = d_revr;
      if (mode_ff == lfd_pkg::MODE_PROPORTIONAL) begin
         if (d_d1 || d_d2) begin
            d_sl = lfd_pkg::DRIVE_W'(c_lb_ff) + d_steer;
            d_sr = lfd_pkg::DRIVE_W'(c_rb_ff) - d_steer;
         end
      end else begin
         if (d_d1 && d_d2) begin
            d_sl = lfd_pkg::DRIVE_W'(c_lb_ff);
            d_sr = lfd_pkg::DRIVE_W'(c_rb_ff);
         end else if (d_le1 && d_d2) begin
            d_sl = lfd_pkg::DRIVE_W'(c_lb_ff);
            d_sr = '0;
         end else if (d_d1 && d_le2) begin
            d_sl = '0;
            d_sr = lfd_pkg::DRIVE_W'(c_rb_ff);
         end
      end
      d_ldrv = drive(d_sl);
      d_rdrv = drive(d_sr);
      rsp_word_in.left_duty     = d_ldrv[lfd_pkg::DUTY_W-1:0];
      rsp_word_in.left_reverse  = d_ldrv[lfd_pkg::DUTY_W];
      rsp_word_in.right_duty    = d_rdrv[lfd_pkg::DUTY_W-1:0];
      rsp_word_in.right_reverse = d_rdrv[lfd_pkg::DUTY_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv_d) begin
         rsp_valid_ff <= c_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_d) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (a_v_ff && b_v_ff && c_v_ff && rsp_valid_ff))
      else $error("request stalled with a bubble in the pipeline");

   a_thresh_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(thresh_ff))
      else $error("threshold changed without an accepted word");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(c_v_ff))
      else $error("response valid without a word in the last stage");

   a_zero_fwd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.left_duty == '0) |-> !rsp_word.left_reverse)
      else $error("left reverse set at zero duty");

endmodule

/* tb/line_follower_drive_tb.sv */
module line_follower_drive_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [lfd_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int DRAIN_CYCLES = 8;
   localparam int IDLE_PCT     = 13;
   localparam int DUTY_MAX     = 255;
   localparam int LIGHT_MAX    = 1023;
   localparam int KNOB_FULL    = 1023;
   localparam int GAIN_SCALE   = 10000;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   lfd_pkg::req_word_type           req_word = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   lfd_pkg::rsp_word_type           rsp_word;
   logic                            csr_wr_en = 1'b0;
   logic [lfd_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [lfd_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   logic                         mode_r      = lfd_pkg::MODE_PROPORTIONAL;
   logic [lfd_pkg::GAIN_W-1:0]   gain_r      = lfd_pkg::GAIN_RESET;
   logic [lfd_pkg::SPEED_W-1:0]  l_base_r    = lfd_pkg::LEFT_BASE_RESET;
   logic [lfd_pkg::SPEED_W-1:0]  l_span_r    = lfd_pkg::LEFT_SPAN_RESET;
   logic [lfd_pkg::SPEED_W-1:0]  r_base_r    = lfd_pkg::RIGHT_BASE_RESET;
   logic [lfd_pkg::SPEED_W-1:0]  r_span_r    = lfd_pkg::RIGHT_SPAN_RESET;
   logic [lfd_pkg::OFFSET_W-1:0] offset_r    = lfd_pkg::OFFSET_RESET;
   logic [lfd_pkg::THRESH_W-1:0] threshold_r = lfd_pkg::THRESH_RESET;

   lfd_pkg::rsp_word_type expected_drive[$];
   int mismatches     = 0;
   int tx_idle_pct    = IDLE_PCT;
   int rx_idle_pct    = IDLE_PCT;
   int rx_hold_cycles = 0;

   line_follower_drive dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #400_000;
      $display("line_follower_drive_tb failed");
      $finish;
   end

   function automatic logic [lfd_pkg::DUTY_W:0] motor_command(input int speed);
      int v;
      v = -speed;
      if (v > DUTY_MAX) v = DUTY_MAX;
      if (v < -DUTY_MAX) v = -DUTY_MAX;
      return (v < 0) ? {1'b1, lfd_pkg::DUTY_W'(-v)} : {1'b0, lfd_pkg::DUTY_W'(v)};
   endfunction

   function automatic lfd_pkg::rsp_word_type predict_drive(input lfd_pkg::req_word_type w);
      int l_in, r_in, th, left_run, right_run, left_speed, right_speed, steer;
      logic left_dark, right_dark;
      lfd_pkg::rsp_word_type r;
      l_in = int'(w.left_light);
      r_in = int'(w.right_light);
      if (w.calibrate)
         threshold_r = lfd_pkg::THRESH_W'((l_in + r_in) / 2 + int'(offset_r));
      th = int'(threshold_r);
      left_run  = int'(l_base_r) + int'(w.speed_knob) * int'(l_span_r) / KNOB_FULL;
      right_run = int'(r_base_r) + int'(w.speed_knob) * int'(r_span_r) / KNOB_FULL;
      left_dark  = l_in >= th;
      right_dark = r_in >= th;
      if (mode_r == lfd_pkg::MODE_PROPORTIONAL && (left_dark || right_dark)) begin
         steer = (l_in - r_in) * int'(gain_r) / GAIN_SCALE;
         left_speed  = left_run + steer;
         right_speed = right_run - steer;
      end else if (mode_r == lfd_pkg::MODE_BANG_BANG && left_dark && right_dark) begin
         left_speed  = left_run;
         right_speed = right_run;
      end else if (mode_r == lfd_pkg::MODE_BANG_BANG && l_in <= th && right_dark) begin
         left_speed  = left_run;
         right_speed = 0;
      end else if (mode_r == lfd_pkg::MODE_BANG_BANG && left_dark && r_in <= th) begin
         left_speed  = 0;
         right_speed = right_run;
      end else begin
         // both light: back up at four fifths
         left_speed  = -(left_run * 4 / 5);
         right_speed = -(right_run * 4 / 5);
      end
      {r.left_reverse, r.left_duty}   = motor_command(left_speed);
      {r.right_reverse, r.right_duty} = motor_command(right_speed);
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic check_drive(input lfd_pkg::rsp_word_type got);
      lfd_pkg::rsp_word_type want;
      if (expected_drive.size() == 0) begin
         report_mismatch($sformatf("unexpected word %h", got));
         return;
      end
      want = expected_drive.pop_front();
      if (got.left_duty !== want.left_duty)
         report_mismatch($sformatf("left_duty %0d, want %0d", got.left_duty, want.left_duty));
      if (got.left_reverse !== want.left_reverse)
         report_mismatch($sformatf("left_reverse %b, want %b",
                                   got.left_reverse, want.left_reverse));
      if (got.right_duty !== want.right_duty)
         report_mismatch($sformatf("right_duty %0d, want %0d",
                                   got.right_duty, want.right_duty));
      if (got.right_reverse !== want.right_reverse)
         report_mismatch($sformatf("right_reverse %b, want %b",
                                   got.right_reverse, want.right_reverse));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_drive(rsp_word);
      if (rx_hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         rx_hold_cycles = rx_hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   task automatic send_word(input lfd_pkg::req_word_type w);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      expected_drive.push_back(predict_drive(w));
   endtask

   task automatic send_reading(input int l_in, input int r_in, input int knob, input bit cal);
      lfd_pkg::req_word_type w;
      w.left_light  = lfd_pkg::LIGHT_W'(l_in);
      w.right_light = lfd_pkg::LIGHT_W'(r_in);
      w.speed_knob  = lfd_pkg::KNOB_W'(knob);
      w.calibrate   = cal;
      send_word(w);
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (expected_drive.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [lfd_pkg::CSR_INDEX_W-1:0] index,
                            input logic [lfd_pkg::CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (index)
         lfd_pkg::CSR_MODE_SELECT:   mode_r   = data[0];
         lfd_pkg::CSR_STEERING_GAIN: gain_r   = data[lfd_pkg::GAIN_W-1:0];
         lfd_pkg::CSR_LEFT_BASE:     l_base_r = data[lfd_pkg::SPEED_W-1:0];
         lfd_pkg::CSR_LEFT_SPAN:     l_span_r = data[lfd_pkg::SPEED_W-1:0];
         lfd_pkg::CSR_RIGHT_BASE:    r_base_r = data[lfd_pkg::SPEED_W-1:0];
         lfd_pkg::CSR_RIGHT_SPAN:    r_span_r = data[lfd_pkg::SPEED_W-1:0];
         lfd_pkg::CSR_CALIB_OFFSET:  offset_r = data[lfd_pkg::OFFSET_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input logic [lfd_pkg::CSR_DATA_W-1:0] mode, gain, l_base,
                                input logic [lfd_pkg::CSR_DATA_W-1:0] l_span, r_base,
                                input logic [lfd_pkg::CSR_DATA_W-1:0] r_span, offset);
      drain_pipeline();
      write_reg(lfd_pkg::CSR_MODE_SELECT, mode);
      write_reg(lfd_pkg::CSR_STEERING_GAIN, gain);
      write_reg(lfd_pkg::CSR_LEFT_BASE, l_base);
      write_reg(lfd_pkg::CSR_LEFT_SPAN, l_span);
      write_reg(lfd_pkg::CSR_RIGHT_BASE, r_base);
      write_reg(lfd_pkg::CSR_RIGHT_SPAN, r_span);
      write_reg(lfd_pkg::CSR_CALIB_OFFSET, offset);
   endtask

   // low bits at min, max or random; garbage above the register width
   function automatic logic [lfd_pkg::CSR_DATA_W-1:0] pick_reg(input int width);
      logic [lfd_pkg::CSR_DATA_W-1:0] v, mask;
      v    = lfd_pkg::CSR_DATA_W'($urandom);
      mask = lfd_pkg::CSR_DATA_W'((32'd1 << width) - 1);
      case ($urandom_range(3))
         0: v = v & ~mask;
         1: v = v | mask;
         default: ;
      endcase
      return v;
   endfunction

   function automatic logic [lfd_pkg::LIGHT_W-1:0] near_threshold();
      int v;
      v = int'(threshold_r) + int'($urandom_range(8)) - 4;
      if (v < 0) v = 0;
      if (v > LIGHT_MAX) v = LIGHT_MAX;
      return lfd_pkg::LIGHT_W'(v);
   endfunction

   function automatic lfd_pkg::req_word_type random_word();
      lfd_pkg::req_word_type w;
      w.left_light  = lfd_pkg::LIGHT_W'($urandom);
      w.right_light = lfd_pkg::LIGHT_W'($urandom);
      w.speed_knob  = lfd_pkg::KNOB_W'($urandom);
      w.calibrate   = ($urandom_range(7) == 0);
      case ($urandom_range(4))
         0: ;
         1: begin
            w.left_light  = near_threshold();
            w.right_light = near_threshold();
         end
         2: begin
            w.left_light  = $urandom_range(1) ? '1 : '0;
            w.right_light = $urandom_range(1) ? '1 : '0;
            w.speed_knob  = $urandom_range(1) ? '1 : '0;
         end
         3: w.left_light = near_threshold();
         default: w.right_light = near_threshold();
      endcase
      return w;
   endfunction

   task automatic test_directed();
      send_reading(0, 0, 0, 0);
      send_reading(LIGHT_MAX, 0, KNOB_FULL, 0);
      send_reading(0, LIGHT_MAX, KNOB_FULL, 0);
      send_reading(300, 299, 512, 0);
      send_reading(LIGHT_MAX, LIGHT_MAX, 0, 1);
      send_reading(LIGHT_MAX, 0, 700, 0);
      send_reading(0, 0, 0, 1);
      apply_setting(16'(lfd_pkg::MODE_PROPORTIONAL), 16'hFFFF, 255, 255, 255, 255, 1023);
      send_reading(LIGHT_MAX, 0, KNOB_FULL, 0);
      send_reading(0, LIGHT_MAX, KNOB_FULL, 0);
      send_reading(LIGHT_MAX, LIGHT_MAX, KNOB_FULL, 1);
      send_reading(0, 0, KNOB_FULL, 1);
      send_reading(LIGHT_MAX, LIGHT_MAX, KNOB_FULL, 0);
      apply_setting(16'(lfd_pkg::MODE_BANG_BANG), 0, 0, 0, 0, 0, 0);
      send_reading(500, 500, KNOB_FULL, 1);
      send_reading(600, 400, 0, 0);
      send_reading(400, 600, 0, 0);
      send_reading(400, 400, 0, 0);
      apply_setting(16'(lfd_pkg::MODE_BANG_BANG), lfd_pkg::GAIN_RESET, 255, 0, 0, 255,
                    16'(lfd_pkg::OFFSET_RESET));
      send_reading(600, 600, KNOB_FULL, 0);
      send_reading(400, 600, KNOB_FULL, 0);
      send_reading(600, 400, KNOB_FULL, 0);
      send_reading(0, 0, KNOB_FULL, 0);
      drain_pipeline();
      write_reg(CSR_UNUSED, 16'hFFFF);
      send_reading(500, 600, 512, 0);
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 0)
            apply_setting(16'(lfd_pkg::MODE_PROPORTIONAL), 0, 0, 0, 0, 0, 0);
         else if (phase == 1)
            apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'hFFFF);
         else
            apply_setting(pick_reg(1), pick_reg(lfd_pkg::GAIN_W), pick_reg(lfd_pkg::SPEED_W),
                          pick_reg(lfd_pkg::SPEED_W), pick_reg(lfd_pkg::SPEED_W),
                          pick_reg(lfd_pkg::SPEED_W), pick_reg(lfd_pkg::OFFSET_W));
         repeat (110) send_word(random_word());
      end
   endtask

   task automatic test_backpressure();
      drain_pipeline();
      rx_hold_cycles = 100;
      repeat (40) send_word(random_word());
   endtask

   task automatic test_steady_stream();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      repeat (120) send_word(random_word());
      tx_idle_pct = IDLE_PCT;
      rx_idle_pct = IDLE_PCT;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_settings();
      test_backpressure();
      test_steady_stream();
      drain_pipeline();
      if (mismatches == 0) begin
         $display("line_follower_drive_tb passed");
      end else begin
         $display("line_follower_drive_tb failed");
      end
      $finish;
   end

endmodule
